// File: rtl/mean_removed_dft_three_channel_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean removed DFT unit
// Concurrent check macros that compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MEAN_REMOVED_DFT_THREE_CHANNEL_UNIT_DEFINES_SVH
`define MEAN_REMOVED_DFT_THREE_CHANNEL_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (c)) else $error("check failed");
`define ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (c)) else $error("check failed");
`else
`define ASSERT_SAME(lbl, a, c)
`define ASSERT_NEXT(lbl, a, c)
`endif
`endif

// File: rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// Mean removed DFT package
// Shared widths, defaults and the twiddle table construction functions.
// ----------------------------------------------------------------------------
package mrd_pkg;
    localparam int SAMPLE_W = 32;
    localparam int BIN_W = 6;
    localparam int ACC_W = 64;
    localparam int NUM_CH = 3;
    localparam int DIV_LANES = 6;
    localparam int DEF_NUM_SAMPLES = 64;
    localparam int DEF_TWIDDLE_BITS = 16;
    localparam longint Q30_ONE = 64'd1073741824;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    function automatic longint taylor_sin(input longint unsigned x);
        longint unsigned x2;
        longint unsigned ts;
        longint s;
        x2 = (x * x) >> 30;
        ts = x;
        s = longint'(x);
        for (int i = 1; i <= 8; i++) begin
            ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if ((i % 2) == 1) s = s - longint'(ts);
            else s = s + longint'(ts);
        end
        if (s < 0) s = 0;
        return s;
    endfunction

    function automatic longint taylor_cos(input longint unsigned x);
        longint unsigned x2;
        longint unsigned tc;
        longint c;
        x2 = (x * x) >> 30;
        tc = Q30_ONE;
        c = Q30_ONE;
        for (int i = 1; i <= 8; i++) begin
            tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
            if ((i % 2) == 1) c = c - longint'(tc);
            else c = c + longint'(tc);
        end
        if (c < 0) c = 0;
        return c;
    endfunction

    function automatic longint q30_to_tw(input longint v, input int tb);
        int sh;
        longint maxmag;
        longint mag;
        sh = 30 - (tb - 1);
        maxmag = (longint'(1) << (tb - 1)) - 1;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        if (mag > maxmag) mag = maxmag;
        return (v < 0) ? -mag : mag;
    endfunction
endpackage

// File: rtl/mrd_twiddle_rom.sv
// ----------------------------------------------------------------------------
// Twiddle table
// Constant sine and cosine table of 2*pi*m/N in signed Q1.(TWIDDLE_BITS-1) format.
// ----------------------------------------------------------------------------
module mrd_twiddle_rom
    import mrd_pkg::*;
#(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
    parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS,
    localparam int AW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1
) (
    input  logic [AW-1:0]                  idx,
    output logic signed [TWIDDLE_BITS-1:0] sin_val,
    output logic signed [TWIDDLE_BITS-1:0] cos_val
);
    logic signed [TWIDDLE_BITS-1:0] sin_tab [NUM_SAMPLES];
    logic signed [TWIDDLE_BITS-1:0] cos_tab [NUM_SAMPLES];

    for (genvar m = 0; m < NUM_SAMPLES; m++) begin : g_rom
        localparam longint Ang = 4 * m;
        localparam longint Quad = Ang / NUM_SAMPLES;
        localparam longint Rem = Ang - Quad * NUM_SAMPLES;
        localparam longint unsigned Xq = (HALF_PI_Q30 * Rem) / NUM_SAMPLES;
        localparam longint Sv = taylor_sin(Xq);
        localparam longint Cv = taylor_cos(Xq);
        localparam longint Rs = ((Quad % 4) == 0) ? Sv : ((Quad % 4) == 1) ? Cv :
                                ((Quad % 4) == 2) ? -Sv : -Cv;
        localparam longint Rc = ((Quad % 4) == 0) ? Cv : ((Quad % 4) == 1) ? -Sv :
                                ((Quad % 4) == 2) ? -Cv : Sv;
        assign sin_tab[m] = TWIDDLE_BITS'(q30_to_tw(Rs, TWIDDLE_BITS));
        assign cos_tab[m] = TWIDDLE_BITS'(q30_to_tw(Rc, TWIDDLE_BITS));
    end

    assign sin_val = sin_tab[idx];
    assign cos_val = cos_tab[idx];
endmodule

// File: rtl/mrd_divn.sv
// ----------------------------------------------------------------------------
// Multi-lane constant divider
// Reciprocal multiplication, ten numerator bits per cycle in every lane.
// ----------------------------------------------------------------------------
module mrd_divn
    import mrd_pkg::*;
#(
    parameter int LANES = DIV_LANES,
    parameter int DIVISOR = DEF_NUM_SAMPLES,
    localparam int NW = ACC_W,
    localparam int DW = 10,
    localparam int STEPS = 4,
    localparam int UW = DW * STEPS,
    localparam int SH = UW + $clog2(DIVISOR),
    localparam int PW = UW + SH,
    localparam int CNTW = $clog2(STEPS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [LANES-1:0][NW-1:0]  num,
    output logic                      done,
    output logic [LANES-1:0][NW-1:0]  quot
);
    // Numerators stay below 2^UW, so a reciprocal rounded up with SH fraction
    // bits gives the exact truncated quotient.
    localparam logic [SH-1:0] RECIP =
        SH'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic [CNTW-1:0]             cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [LANES-1:0][UW-1:0]    n_reg;
    logic [LANES-1:0][PW-1:0]    acc_reg;
    logic [LANES-1:0][SH+DW-1:0] part;
    logic [LANES-1:0][PW-1:0]    acc_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            part[l] = RECIP * n_reg[l][UW-1 -: DW];
            acc_next[l] = (acc_reg[l] << DW) + PW'(part[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNTW'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (start)
            begin
                n_reg[l] <= num[l][UW-1:0];
                acc_reg[l] <= '0;
            end
            else if (busy_reg)
            begin
                n_reg[l] <= n_reg[l] << DW;
                acc_reg[l] <= acc_next[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quot[l] = NW'(acc_reg[l][PW-1:SH]);
        end
    end

    assign done = done_reg;
endmodule

// File: rtl/mrd_isqrt.sv
// ----------------------------------------------------------------------------
// Multi-lane integer square root
// Bitwise square root of 64-bit values, one result bit per cycle per lane.
// ----------------------------------------------------------------------------
module mrd_isqrt
    import mrd_pkg::*;
#(
    parameter int LANES = NUM_CH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [LANES-1:0][ACC_W-1:0] val,
    output logic                        done,
    output logic [LANES-1:0][31:0]      root
);
    logic [5:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [ACC_W-1:0]            bit_reg;
    logic [LANES-1:0][ACC_W-1:0] v_reg;
    logic [LANES-1:0][ACC_W-1:0] res_reg;
    logic [LANES-1:0][ACC_W-1:0] v_next;
    logic [LANES-1:0][ACC_W-1:0] res_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (v_reg[l] >= res_reg[l] + bit_reg)
            begin
                v_next[l] = v_reg[l] - (res_reg[l] + bit_reg);
                res_next[l] = (res_reg[l] >> 1) + bit_reg;
            end
            else
            begin
                v_next[l] = v_reg[l];
                res_next[l] = res_reg[l] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 6'd32;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= val;
            res_reg <= '0;
            bit_reg <= ACC_W'(64'h4000_0000_0000_0000);
        end
        else if (busy_reg)
        begin
            v_reg <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = res_reg[l][31:0];
        end
    end

    assign done = done_reg;
endmodule

// File: rtl/mean_removed_dft_three_channel_unit.sv
// ----------------------------------------------------------------------------
// Mean removed three channel DFT unit
// Stores a record of sample triples and streams out a per-bin spectrum.
// ----------------------------------------------------------------------------
// The unit takes NUM_SAMPLES requests, one per cycle, and is then busy until
// the whole spectrum has been delivered. One shared multiply-accumulate pass
// over the stored record computes each bin, followed by a reciprocal
// multiplication for the scaling and a square root for the magnitude; the
// MAC loop over the sample memory dominates for large NUM_SAMPLES.
`include "mean_removed_dft_three_channel_unit_defines.svh"
module mean_removed_dft_three_channel_unit
    import mrd_pkg::*;
#(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
    parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // temperature_sample, force_sample, velocity_sample
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_index, temp sine/cosine/magnitude, force sine/cosine/magnitude,
    // vel sine/cosine/magnitude, two zero pad bits
    output logic [295:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int AW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int CW = AW + 1;
    localparam int SUM_W = SAMPLE_W + AW + 1;
    localparam int PW = SAMPLE_W + 1 + TWIDDLE_BITS;
    localparam logic [ACC_W-1:0] HALF_DIV = ACC_W'(NUM_SAMPLES) << (TWIDDLE_BITS - 2);
    localparam logic [ACC_W-1:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0] NEG_MAX = 64'h0000_0000_8000_0000;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_MEAN  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_SQ    = 3'd5;
    localparam logic [2:0] S_SQRT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [CW-1:0] t_reg;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] m_reg;
    logic [AW:0]   m_sum;
    logic [AW-1:0] m_next;
    logic          v1_reg;
    logic          v2_reg;
    logic          div_start_reg;
    logic          sqrt_start_reg;
    logic          iss;
    logic          in_acc;
    logic          out_acc;
    logic          phase_change;

    logic [SAMPLE_W-1:0] smem [NUM_CH][NUM_SAMPLES];
    sample_t             rd_reg [NUM_CH];
    logic signed [TWIDDLE_BITS-1:0] tw_sin;
    logic signed [TWIDDLE_BITS-1:0] tw_cos;
    logic signed [TWIDDLE_BITS-1:0] tws_reg;
    logic signed [TWIDDLE_BITS-1:0] twc_reg;
    logic signed [SUM_W-1:0]  sum_reg [NUM_CH];
    sample_t                  mean_reg [NUM_CH];
    logic signed [SAMPLE_W:0] xc [NUM_CH];
    logic signed [PW-1:0]     prs_reg [NUM_CH];
    logic signed [PW-1:0]     prc_reg [NUM_CH];
    logic signed [ACC_W-1:0]  accs_reg [NUM_CH];
    logic signed [ACC_W-1:0]  accc_reg [NUM_CH];
    sample_t                  sp_reg [NUM_CH];
    sample_t                  cp_reg [NUM_CH];
    logic [ACC_W-1:0]         sqs_reg [NUM_CH];
    logic [ACC_W-1:0]         sqc_reg [NUM_CH];
    logic [31:0]              mag_reg [NUM_CH];

    logic [DIV_LANES-1:0][ACC_W-1:0] div_num;
    logic [DIV_LANES-1:0][ACC_W-1:0] div_quot;
    logic                            div_done;
    logic [NUM_CH-1:0][ACC_W-1:0]    sq_val;
    logic [NUM_CH-1:0][31:0]         sq_root;
    logic                            sqrt_done;
    logic [ACC_W-1:0]                mag_tmp;
    logic [ACC_W-1:0]                sum_abs;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tlast = (k_reg == AW'(NUM_SAMPLES - 1));
    assign iss = ((state_reg == S_SUM) || (state_reg == S_MAC)) &&
                 (t_reg != CW'(NUM_SAMPLES));
    assign phase_change = (state_next != state_reg);
    assign m_sum = {1'b0, m_reg} + {1'b0, k_reg};
    assign m_next = (m_sum >= (AW+1)'(NUM_SAMPLES)) ?
                    AW'(m_sum - (AW+1)'(NUM_SAMPLES)) : AW'(m_sum);

    mrd_twiddle_rom #(.NUM_SAMPLES(NUM_SAMPLES), .TWIDDLE_BITS(TWIDDLE_BITS)) u_rom (
        .idx(m_reg), .sin_val(tw_sin), .cos_val(tw_cos)
    );

    mrd_divn #(.LANES(DIV_LANES), .DIVISOR(NUM_SAMPLES)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .num(div_num),
        .done(div_done), .quot(div_quot)
    );

    mrd_isqrt #(.LANES(NUM_CH)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start_reg), .val(sq_val),
        .done(sqrt_done), .root(sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:  if (in_acc && cnt_reg == AW'(NUM_SAMPLES - 1)) state_next = S_SUM;
            S_SUM:   if (t_reg == CW'(NUM_SAMPLES) && !v1_reg) state_next = S_MEAN;
            S_MEAN:  if (div_done) state_next = S_MAC;
            S_MAC:   if (t_reg == CW'(NUM_SAMPLES) && !v1_reg && !v2_reg)
                         state_next = S_SCALE;
            S_SCALE: if (div_done) state_next = S_SQ;
            S_SQ:    state_next = S_SQRT;
            S_SQRT:  if (sqrt_done) state_next = S_OUT;
            S_OUT:   if (out_acc)
                         state_next = m_axis_tlast ? S_LOAD : S_MAC;
            default: state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        mag_tmp = '0;
        sum_abs = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_abs = sum_reg[c][SUM_W-1] ? ACC_W'(-sum_reg[c]) : ACC_W'(sum_reg[c]);
            if (state_reg == S_MEAN)
            begin
                div_num[c] = sum_abs;
                div_num[c + NUM_CH] = '0;
            end
            else
            begin
                mag_tmp = accs_reg[c][ACC_W-1] ? ACC_W'(-accs_reg[c]) : ACC_W'(accs_reg[c]);
                div_num[c] = (mag_tmp + HALF_DIV) >> (TWIDDLE_BITS - 1);
                mag_tmp = accc_reg[c][ACC_W-1] ? ACC_W'(-accc_reg[c]) : ACC_W'(accc_reg[c]);
                div_num[c + NUM_CH] = (mag_tmp + HALF_DIV) >> (TWIDDLE_BITS - 1);
            end
            xc[c] = {rd_reg[c][SAMPLE_W-1], rd_reg[c]} - {mean_reg[c][SAMPLE_W-1], mean_reg[c]};
            sq_val[c] = sqs_reg[c] + sqc_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            t_reg <= '0;
            k_reg <= '0;
            m_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            div_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg <= iss;
            v2_reg <= v1_reg && (state_reg == S_MAC);
            div_start_reg <= phase_change &&
                             ((state_next == S_MEAN) || (state_next == S_SCALE));
            sqrt_start_reg <= (state_reg == S_SQ);
            if (in_acc)
            begin
                cnt_reg <= (cnt_reg == AW'(NUM_SAMPLES - 1)) ? '0 : cnt_reg + 1'b1;
            end
            if (phase_change)
            begin
                t_reg <= '0;
                m_reg <= '0;
            end
            else if (iss)
            begin
                t_reg <= t_reg + 1'b1;
                m_reg <= m_next;
            end
            if (out_acc)
            begin
                k_reg <= m_axis_tlast ? '0 : k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tws_reg <= tw_sin;
        twc_reg <= tw_cos;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (in_acc)
            begin
                smem[c][cnt_reg] <= s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
            end
            rd_reg[c] <= smem[c][t_reg[AW-1:0]];
            prs_reg[c] <= xc[c] * tws_reg;
            prc_reg[c] <= xc[c] * twc_reg;
            if (state_reg == S_SUM && phase_change == 1'b0 && t_reg == '0 && !v1_reg)
            begin
                sum_reg[c] <= '0;
            end
            else if (state_reg == S_SUM && v1_reg)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(rd_reg[c]);
            end
            if (state_reg == S_MEAN && div_done)
            begin
                mean_reg[c] <= sum_reg[c][SUM_W-1] ? -div_quot[c][SAMPLE_W-1:0]
                                                   : div_quot[c][SAMPLE_W-1:0];
            end
            if (phase_change && state_next == S_MAC)
            begin
                accs_reg[c] <= '0;
                accc_reg[c] <= '0;
            end
            else if (v2_reg)
            begin
                accs_reg[c] <= accs_reg[c] - ACC_W'(prs_reg[c]);
                accc_reg[c] <= accc_reg[c] + ACC_W'(prc_reg[c]);
            end
            if (state_reg == S_SCALE && div_done)
            begin
                if (accs_reg[c][ACC_W-1])
                    sp_reg[c] <= (div_quot[c] > NEG_MAX) ? sample_t'(NEG_MAX[31:0])
                                                         : -div_quot[c][31:0];
                else
                    sp_reg[c] <= (div_quot[c] > POS_MAX) ? sample_t'(POS_MAX[31:0])
                                                         : div_quot[c][31:0];
                if (accc_reg[c][ACC_W-1])
                    cp_reg[c] <= (div_quot[c+NUM_CH] > NEG_MAX) ? sample_t'(NEG_MAX[31:0])
                                                                : -div_quot[c+NUM_CH][31:0];
                else
                    cp_reg[c] <= (div_quot[c+NUM_CH] > POS_MAX) ? sample_t'(POS_MAX[31:0])
                                                                : div_quot[c+NUM_CH][31:0];
            end
            if (state_reg == S_SQ)
            begin
                sqs_reg[c] <= ACC_W'(sp_reg[c] * sp_reg[c]);
                sqc_reg[c] <= ACC_W'(cp_reg[c] * cp_reg[c]);
            end
            if (sqrt_done)
            begin
                mag_reg[c] <= sq_root[c];
            end
        end
    end

    assign m_axis_tdata = {2'b00,
                           mag_reg[2], cp_reg[2], sp_reg[2],
                           mag_reg[1], cp_reg[1], sp_reg[1],
                           mag_reg[0], cp_reg[0], sp_reg[0],
                           BIN_W'(k_reg)};

    `ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_ready_after_last, out_acc && m_axis_tlast, s_axis_tready)
    `ASSERT_SAME(a_mac_index_range, iss, t_reg < CW'(NUM_SAMPLES))
endmodule

// File: verif/mean_removed_dft_three_channel_unit_checker.sv
// ----------------------------------------------------------------------------
// Spectrum checker for the mean removed DFT unit
// Watches both stream channels. It keeps its own copy of the sample record,
// builds the twiddle table and computes the expected bins of each completed
// record. It then compares every delivered bin field by field, in order.
// ----------------------------------------------------------------------------
module mean_removed_dft_three_channel_unit_checker
    import mrd_pkg::*;
#(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
    parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [295:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           mismatches,
    output int           bins_pending,
    output int           bins_seen,
    output int           records_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_SHIFT = 30 - (TWIDDLE_BITS - 1);
    localparam longint TW_MAX = (longint'(1) << (TWIDDLE_BITS - 1)) - 1;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [31:0]      sin_part [NUM_CH];
        logic [31:0]      cos_part [NUM_CH];
        logic [31:0]      mag      [NUM_CH];
        logic             last;
    } bin_result_t;

    bin_result_t expected_bins[$];
    longint twiddle_sin [NUM_SAMPLES];
    longint twiddle_cos [NUM_SAMPLES];
    sample_t record_buf [NUM_CH][NUM_SAMPLES];
    int fill_count;

    function automatic longint to_twiddle(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (mag > TW_MAX) mag = TW_MAX;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic [31:0] scale_to_q16(input longint acc);
        longint unsigned div;
        longint unsigned mag;
        div = longint'(NUM_SAMPLES) << (TWIDDLE_BITS - 1);
        mag = (acc < 0) ? longint'(-acc) : longint'(acc);
        mag = (mag + div / 2) / div;
        if (acc < 0) begin
            if (mag > 64'd2147483648) mag = 64'd2147483648;
            return 32'(-longint'(mag));
        end
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        return 32'(mag);
    endfunction

    function automatic logic [31:0] root_floor(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = longint'(1) << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return 32'(root);
    endfunction

    initial begin
        longint unsigned x, x2, ts, tc;
        longint s, c, quad, rem;
        for (int m = 0; m < NUM_SAMPLES; m++) begin
            quad = (4 * m) / NUM_SAMPLES;
            rem = 4 * m - quad * NUM_SAMPLES;
            x = (HALF_PI_Q30 * rem) / NUM_SAMPLES;
            x2 = (x * x) >> 30;
            ts = x;
            tc = Q30_ONE;
            s = longint'(x);
            c = Q30_ONE;
            for (int i = 1; i <= 8; i++) begin
                ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
                tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
                if (i % 2 == 1) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) s = 0;
            if (c < 0) c = 0;
            case (quad % 4)
                0: begin twiddle_sin[m] = to_twiddle(s);  twiddle_cos[m] = to_twiddle(c);  end
                1: begin twiddle_sin[m] = to_twiddle(c);  twiddle_cos[m] = to_twiddle(-s); end
                2: begin twiddle_sin[m] = to_twiddle(-s); twiddle_cos[m] = to_twiddle(-c); end
                default: begin
                    twiddle_sin[m] = to_twiddle(-c);
                    twiddle_cos[m] = to_twiddle(s);
                end
            endcase
        end
    end

    task automatic predict_spectrum();
        longint centred [NUM_CH][NUM_SAMPLES];
        longint total, mean, acc_s, acc_c;
        bin_result_t r;
        logic signed [31:0] sp, cp;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            total = 0;
            for (int t = 0; t < NUM_SAMPLES; t++) total += longint'(record_buf[ch][t]);
            mean = total / NUM_SAMPLES;
            for (int t = 0; t < NUM_SAMPLES; t++)
                centred[ch][t] = longint'(record_buf[ch][t]) - mean;
        end
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            r.bin = BIN_W'(k);
            r.last = (k == NUM_SAMPLES - 1);
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc_s = 0;
                acc_c = 0;
                for (int t = 0; t < NUM_SAMPLES; t++) begin
                    acc_s -= centred[ch][t] * twiddle_sin[(k * t) % NUM_SAMPLES];
                    acc_c += centred[ch][t] * twiddle_cos[(k * t) % NUM_SAMPLES];
                end
                sp = scale_to_q16(acc_s);
                cp = scale_to_q16(acc_c);
                r.sin_part[ch] = sp;
                r.cos_part[ch] = cp;
                r.mag[ch] = root_floor(longint'(unsigned'(longint'(sp) * sp))
                                       + longint'(unsigned'(longint'(cp) * cp)));
            end
            expected_bins.push_back(r);
        end
    endtask

    task automatic compare_field(input string label, input int bin,
                                 input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH bin %0d %s: expected %h, got %h", bin, label, want, got);
        end
    endtask

    assign bins_pending = expected_bins.size();

    always @(posedge clk or negedge rst_n) begin
        bin_result_t want;
        if (!rst_n) begin
            fill_count <= 0;
            mismatches = 0;
            bins_seen = 0;
            records_done = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    record_buf[ch][fill_count] = s_axis_tdata[32*ch +: 32];
                if (fill_count == NUM_SAMPLES - 1) begin
                    predict_spectrum();
                    records_done++;
                    fill_count <= 0;
                end else begin
                    fill_count <= fill_count + 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                bins_seen++;
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("UNEXPECTED bin output %h", m_axis_tdata[BIN_W-1:0]);
                end else begin
                    want = expected_bins.pop_front();
                    compare_field("bin_index", want.bin, 32'(want.bin),
                                  32'(m_axis_tdata[BIN_W-1:0]));
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        compare_field($sformatf("ch%0d sine", ch), want.bin,
                                      want.sin_part[ch], m_axis_tdata[6 + 96*ch +: 32]);
                        compare_field($sformatf("ch%0d cosine", ch), want.bin,
                                      want.cos_part[ch], m_axis_tdata[38 + 96*ch +: 32]);
                        compare_field($sformatf("ch%0d magnitude", ch), want.bin,
                                      want.mag[ch], m_axis_tdata[70 + 96*ch +: 32]);
                    end
                    compare_field("last_bin", want.bin, 32'(want.last), 32'(m_axis_tlast));
                end
            end
        end
    end
endmodule

// File: verif/tb_mean_removed_dft_three_channel_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the mean removed three channel DFT unit
// Streams several sample records under different idle and stall patterns,
// including a long output hold-off, and lets the checker verify every bin.
// ----------------------------------------------------------------------------
module tb_mean_removed_dft_three_channel_unit;
    import mrd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = DEF_NUM_SAMPLES;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 3000;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [295:0] m_axis_tdata;
    logic         m_axis_tlast;

    int mismatches;
    int bins_pending;
    int bins_seen;
    int records_done;
    int cycle_count;
    int hold_left;
    idle_phase_t phase;

    mean_removed_dft_three_channel_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    mean_removed_dft_three_channel_unit_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .mismatches(mismatches),
        .bins_pending(bins_pending),
        .bins_seen(bins_seen),
        .records_done(records_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_mean_removed_dft_three_channel_unit NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (phase == PH_RECV_STALL)
            m_axis_tready <= ($urandom_range(99) >= 67);
        else if (phase == PH_BOTH_IDLE)
            m_axis_tready <= ($urandom_range(99) >= 8);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_triple(input logic [31:0] temp, input logic [31:0] force_v,
                               input logic [31:0] vel);
        int gap_pct;
        gap_pct = (phase == PH_SEND_IDLE) ? 67 : (phase == PH_BOTH_IDLE) ? 8 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vel, force_v, temp};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_extreme(input int sel);
        case (sel % 6)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h8000_0001;
        endcase
    endfunction

    initial
    begin
        logic [31:0] c0, c1, c2;
        int amp;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cycle_count = 0;
        hold_left = 0;
        phase = PH_FREE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Record of extremes, square waves and full range noise with no idling.
        for (int t = 0; t < N; t++)
        begin
            if (t < 24)
                send_triple(pick_extreme(t), pick_extreme(t / 6 + t), pick_extreme(5 - t));
            else if (t < 40)
                send_triple((t < 32) ? 32'h7FFF_FFFF : 32'h8000_0000,
                            (t % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom());
            else
                send_triple($urandom(), $urandom(), $urandom());
        end

        // Constant record: the mean removal leaves an all-zero spectrum.
        phase = PH_SEND_IDLE;
        c0 = $urandom();
        c1 = $urandom();
        c2 = $urandom();
        for (int t = 0; t < N; t++)
            send_triple(c0, c1, c2);

        // The output side holds off for a long stretch while requests keep coming.
        phase = PH_RECV_STALL;
        hold_left = HOLD_CYCLES;
        for (int t = 0; t < N; t++)
            send_triple($urandom(), $urandom(), $urandom());

        phase = PH_BOTH_IDLE;
        amp = $urandom_range(20, 4);
        for (int t = 0; t < N; t++)
            send_triple($signed($urandom()) >>> amp, $signed($urandom()) >>> amp,
                        $signed($urandom()) >>> amp);
        s_axis_tvalid <= 1'b0;

        // Let the checker queue the bins of the final record first.
        @(posedge clk);
        while (bins_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d records and %0d bins under free, sender idle, receiver stall,",
                 records_done, bins_seen);
        $display("long hold-off and mixed idle phases with %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("tb_mean_removed_dft_three_channel_unit OK");
        else
            $display("tb_mean_removed_dft_three_channel_unit NOT OK");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/mrd_pkg.sv
rtl/mrd_twiddle_rom.sv
rtl/mrd_divn.sv
rtl/mrd_isqrt.sv
rtl/mean_removed_dft_three_channel_unit.sv
verif/mean_removed_dft_three_channel_unit_checker.sv
verif/tb_mean_removed_dft_three_channel_unit.sv
